// File: design/lbl_pkg.sv
// ----------------------------------------------------------------------------
// lbl_pkg
// Shared types and fixed constants of the lab-frame Lorentz boost pipeline.
// ----------------------------------------------------------------------------
package lbl_pkg;

  // Width of every four-vector component (signed Q16.16 GeV).
  localparam int FIELD_W = 32;

  // Square root: radicand width, root width and root bits resolved per stage.
  localparam int RAD_W     = 64;
  localparam int ROOT_W    = 32;
  localparam int SQRT_BITS = 2;

  // Division: quotient bits kept before saturation and bits resolved per stage.
  localparam int QUO_W    = 34;
  localparam int DIV_BITS = 2;

  // One input beat: parent four-vector in the lab, daughter in the parent frame.
  typedef struct packed {
    logic signed [FIELD_W-1:0] parent_px;
    logic signed [FIELD_W-1:0] parent_py;
    logic signed [FIELD_W-1:0] parent_pz;
    logic signed [FIELD_W-1:0] parent_energy;
    logic signed [FIELD_W-1:0] daughter_px;
    logic signed [FIELD_W-1:0] daughter_py;
    logic signed [FIELD_W-1:0] daughter_pz;
    logic signed [FIELD_W-1:0] daughter_energy;
  } in_t;

  // One output beat: boosted daughter and the bad parent flag.
  typedef struct packed {
    logic signed [FIELD_W-1:0] lab_px;
    logic signed [FIELD_W-1:0] lab_py;
    logic signed [FIELD_W-1:0] lab_pz;
    logic signed [FIELD_W-1:0] lab_energy;
    logic                      bad_parent;
  } out_t;

endpackage

// File: design/lbl_isqrt.sv
// ----------------------------------------------------------------------------
// lbl_isqrt
// Pipelined digit-by-digit integer square root, floor(sqrt(rad)), with a
// sideband that travels alongside the radicand.
// ----------------------------------------------------------------------------
module lbl_isqrt #(
  parameter int TW = 1
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         en,
  input  logic                         vld_in,
  input  logic [lbl_pkg::RAD_W-1:0]    rad,
  input  logic [TW-1:0]                tag,
  output logic                         vld_out,
  output logic [lbl_pkg::ROOT_W-1:0]   root,
  output logic [TW-1:0]                tag_out
);
  import lbl_pkg::*;

  localparam int NS = ROOT_W / SQRT_BITS;
  localparam int RW = ROOT_W + 2;
  localparam int SW = RW + ROOT_W + RAD_W;

  logic [NS:0]       vld;
  logic [RW-1:0]     rem      [NS+1];
  logic [ROOT_W-1:0] rt       [NS+1];
  logic [RAD_W-1:0]  src      [NS+1];
  logic [TW-1:0]     tg       [NS+1];
  logic [RW-1:0]     rem_next [NS];
  logic [ROOT_W-1:0] rt_next  [NS];
  logic [RAD_W-1:0]  src_next [NS];

  // One radix-4 step: bring down two radicand bits and try 4*root+1.
  function automatic logic [SW-1:0] sq_step(input logic [SW-1:0] acc);
    logic [RW-1:0]     r;
    logic [RW-1:0]     rw;
    logic [RW-1:0]     tr;
    logic [ROOT_W-1:0] q;
    logic [RAD_W-1:0]  s;
    {r, q, s} = acc;
    rw = {r[RW-3:0], s[RAD_W-1 -: 2]};
    tr = {q, 2'b01};
    s  = s << 2;
    if (rw >= tr) begin
      r = rw - tr;
      q = {q[ROOT_W-2:0], 1'b1};
    end else begin
      r = rw;
      q = {q[ROOT_W-2:0], 1'b0};
    end
    return {r, q, s};
  endfunction

  // Each stage resolves SQRT_BITS root bits.
  always_comb begin : step_comb
    logic [SW-1:0] acc;
    for (int k = 0; k < NS; k++) begin
      acc = {rem[k], rt[k], src[k]};
      for (int j = 0; j < SQRT_BITS; j++) begin
        acc = sq_step(acc);
      end
      {rem_next[k], rt_next[k], src_next[k]} = acc;
    end
  end

  // Valid bits, cleared by reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NS-1:0], vld_in};
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= '0;
      rt[0]  <= '0;
      src[0] <= rad;
      tg[0]  <= tag;
      for (int k = 0; k < NS; k++) begin
        rem[k+1] <= rem_next[k];
        rt[k+1]  <= rt_next[k];
        src[k+1] <= src_next[k];
        tg[k+1]  <= tg[k];
      end
    end
  end

  assign vld_out = vld[NS];
  assign root    = rt[NS];
  assign tag_out = tg[NS];

endmodule

// File: design/lbl_div.sv
// ----------------------------------------------------------------------------
// lbl_div
// Pipelined restoring divider. The quotient is QUO_W bits wide and reads as
// all ones when the true quotient does not fit.
// ----------------------------------------------------------------------------
module lbl_div #(
  parameter int NW = 66,
  parameter int DW = 32,
  parameter int TW = 1
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  logic                        vld_in,
  input  logic [NW-1:0]               num,
  input  logic [DW-1:0]               den,
  input  logic [TW-1:0]               tag,
  output logic                        vld_out,
  output logic [lbl_pkg::QUO_W-1:0]   quo,
  output logic [TW-1:0]               tag_out
);
  import lbl_pkg::*;

  localparam int QW = QUO_W;
  localparam int NS = QW / DIV_BITS;
  localparam int HW = NW - QW;
  localparam int CW = (HW > DW) ? HW : DW;
  localparam int AW = DW + 2 * QW;

  logic [NS:0]   vld;
  logic [NS:0]   ovf;
  logic [DW-1:0] rem      [NS+1];
  logic [QW-1:0] low      [NS+1];
  logic [QW-1:0] qt       [NS+1];
  logic [DW-1:0] dsr      [NS+1];
  logic [TW-1:0] tg       [NS+1];
  logic [DW-1:0] rem_next [NS];
  logic [QW-1:0] low_next [NS];
  logic [QW-1:0] qt_next  [NS];
  logic [CW-1:0] hi_ext;
  logic [CW-1:0] den_ext;

  // One restoring step: shift in the next numerator bit and try a subtract.
  function automatic logic [AW-1:0] dv_step(input logic [AW-1:0] acc,
                                            input logic [DW-1:0] d);
    logic [DW-1:0] r;
    logic [QW-1:0] l;
    logic [QW-1:0] q;
    logic [DW:0]   rw;
    {r, l, q} = acc;
    rw = {r, l[QW-1]};
    l  = l << 1;
    if (rw >= {1'b0, d}) begin
      rw = rw - {1'b0, d};
      q  = {q[QW-2:0], 1'b1};
    end else begin
      q  = {q[QW-2:0], 1'b0};
    end
    r = rw[DW-1:0];
    return {r, l, q};
  endfunction

  // The quotient overflows when the upper numerator part reaches the divisor.
  assign hi_ext  = CW'(num[NW-1:QW]);
  assign den_ext = CW'(den);

  always_comb begin : step_comb
    logic [AW-1:0] acc;
    for (int k = 0; k < NS; k++) begin
      acc = {rem[k], low[k], qt[k]};
      for (int j = 0; j < DIV_BITS; j++) begin
        acc = dv_step(acc, dsr[k]);
      end
      {rem_next[k], low_next[k], qt_next[k]} = acc;
    end
  end

  // Valid bits, cleared by reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NS-1:0], vld_in};
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= DW'(num[NW-1:QW]);
      low[0] <= num[QW-1:0];
      qt[0]  <= '0;
      dsr[0] <= den;
      ovf[0] <= (hi_ext >= den_ext);
      tg[0]  <= tag;
      for (int k = 0; k < NS; k++) begin
        rem[k+1] <= rem_next[k];
        low[k+1] <= low_next[k];
        qt[k+1]  <= qt_next[k];
        dsr[k+1] <= dsr[k];
        ovf[k+1] <= ovf[k];
        tg[k+1]  <= tg[k];
      end
    end
  end

  assign vld_out = vld[NS];
  assign quo     = ovf[NS] ? '1 : qt[NS];
  assign tag_out = tg[NS];

endmodule

// File: design/lorentz_boost_to_lab.sv
// ----------------------------------------------------------------------------
// lorentz_boost_to_lab
// Boosts a daughter four-vector from its parent's rest frame into the lab.
// Input beats carry the parent (px, py, pz, E) and the daughter in the parent
// frame; output beats carry the lab-frame daughter and a bad parent flag.
// Both channels use valid/ready; one output beat follows each input beat.
// One beat is accepted every cycle while in_ready is high. The depth is set by
// the square root (16 stages of two root bits) and the dividers (17 stages of
// two quotient bits).
// The parent mass is floor(sqrt(E^2-|P|^2)); each quotient rounds to nearest,
// ties away from zero, and results saturate to the 32-bit range. A parent
// with non-positive mass squared gives zeros and bad_parent set.
// Reset empties the pipeline. When the receiver stalls with a result waiting,
// the whole pipeline holds and in_ready drops until the beat is taken.
// ----------------------------------------------------------------------------
module lorentz_boost_to_lab (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  lbl_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output lbl_pkg::out_t out_data
);
  import lbl_pkg::*;

  // Sideband carried through the square root.
  typedef struct packed {
    logic             bad;
    logic [31:0]      e_mag;
    logic [65:0]      s;
    logic [66:0]      ne;
    logic [31:0]      de;
    logic [2:0][31:0] a;
    logic [2:0][31:0] d;
  } sqt_t;

  function automatic logic signed [63:0] sx64(input logic [31:0] x);
    return $signed({{32{x[31]}}, x});
  endfunction

  function automatic logic [31:0] sat32(input logic signed [35:0] v);
    if (v > 36'sh07FFFFFFF) begin
      return 32'h7FFFFFFF;
    end else if (v < -36'sh080000000) begin
      return 32'h80000000;
    end else begin
      return v[31:0];
    end
  endfunction

  function automatic logic signed [35:0] sgn_quo(input logic [QUO_W-1:0] q,
                                                 input logic neg);
    logic signed [35:0] t;
    t = $signed({2'b00, q});
    return neg ? -t : t;
  endfunction

  logic en;

  // Stage 1: input register.
  logic v_s1;
  in_t  s1;
  logic [2:0][31:0] a1, d1;
  logic [31:0] emag1;

  // Stage 2: products.
  logic v_s2;
  logic [2:0][31:0] a2, d2;
  logic [31:0] de2, emag2;
  logic [2:0][63:0] sq2, ad2;
  logic [63:0] esq2, ed2;

  // Stage 3 (combinational into the square root).
  logic [63:0] p2, m2v;
  logic        bad3;
  logic [65:0] s3;
  sqt_t sq_in, sq_out;
  logic v_sq;
  logic [31:0] root;

  // Post-root stages.
  logic v_m1, v_m2, v_m3, v_m4, v_m5;
  sqt_t k1, k2, k3;
  logic [31:0] m_1, m_2, m_3, m_4, m_5;
  logic [32:0] epm1;
  logic [63:0] den2, den3, den4, den5;
  logic [65:0] dep2;
  logic [66:0] nc3;
  logic [66:0] nc_abs, ne_abs;
  logic [2:0][31:0] amag3;
  logic bad4, ne_neg4, nc_neg4;
  logic [65:0] ne_mag4, nc_mag4;
  logic [2:0][31:0] amag4, d4, d5;
  logic [2:0] aneg4, tneg5;
  logic bad5, ne_neg5;
  logic [65:0] enum5;
  logic [2:0][64:0] ph5, pl5;
  logic [2:0][98:0] nump;

  // Divider outputs.
  logic vd_e;
  logic [QUO_W-1:0] qe;
  logic [1:0] tg_e;
  logic [2:0] vd_p;
  logic [2:0][QUO_W-1:0] qp;
  logic [2:0][32:0] tgp;
  out_t out_next;

  // The whole pipeline advances unless a result waits on a stalled receiver.
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  // Valid bits of the top-level stages.
  always_ff @(posedge clk) begin
    if (rst) begin
      v_s1 <= 1'b0;
      v_s2 <= 1'b0;
      v_m1 <= 1'b0;
      v_m2 <= 1'b0;
      v_m3 <= 1'b0;
      v_m4 <= 1'b0;
      v_m5 <= 1'b0;
    end else if (en) begin
      v_s1 <= in_valid;
      v_s2 <= v_s1;
      v_m1 <= v_sq;
      v_m2 <= v_m1;
      v_m3 <= v_m2;
      v_m4 <= v_m3;
      v_m5 <= v_m4;
    end
  end

  // Component views of the input register and the parent energy magnitude.
  assign a1    = {s1.parent_pz, s1.parent_py, s1.parent_px};
  assign d1    = {s1.daughter_pz, s1.daughter_py, s1.daughter_px};
  assign emag1 = s1.parent_energy[31] ? (~s1.parent_energy + 32'd1) : s1.parent_energy;

  // Input register and the product stage.
  always_ff @(posedge clk) begin
    if (en) begin
      s1    <= in_data;
      a2    <= a1;
      d2    <= d1;
      de2   <= s1.daughter_energy;
      emag2 <= emag1;
      for (int i = 0; i < 3; i++) begin
        sq2[i] <= sx64(a1[i]) * sx64(a1[i]);
        ad2[i] <= sx64(a1[i]) * sx64(d1[i]);
      end
      esq2 <= {32'b0, emag1} * {32'b0, emag1};
      ed2  <= $signed({32'b0, emag1}) * sx64(s1.daughter_energy);
    end
  end

  // Mass squared, its sign check and the dot products.
  always_comb begin
    p2   = sq2[0] + sq2[1] + sq2[2];
    bad3 = (p2 >= esq2);
    m2v  = bad3 ? 64'd0 : (esq2 - p2);
    s3   = {{2{ad2[0][63]}}, ad2[0]} + {{2{ad2[1][63]}}, ad2[1]}
         + {{2{ad2[2][63]}}, ad2[2]};
    sq_in.bad   = bad3;
    sq_in.e_mag = emag2;
    sq_in.s     = s3;
    sq_in.ne    = {s3[65], s3} + {{3{ed2[63]}}, ed2};
    sq_in.de    = de2;
    sq_in.a     = a2;
    sq_in.d     = d2;
  end

  lbl_isqrt #(.TW($bits(sqt_t))) u_isqrt (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .vld_in  (v_s2),
    .rad     (m2v),
    .tag     (sq_in),
    .vld_out (v_sq),
    .root    (root),
    .tag_out (sq_out)
  );

  // Magnitudes of the numerators and the parent momentum components.
  always_comb begin
    nc_abs = nc3[66] ? (~nc3 + 67'd1) : nc3;
    ne_abs = k3.ne[66] ? (~k3.ne + 67'd1) : k3.ne;
    for (int i = 0; i < 3; i++) begin
      amag3[i] = k3.a[i][31] ? (~k3.a[i] + 32'd1) : k3.a[i];
    end
  end

  // Stages after the root: E+m, products, numerator, magnitudes, partials.
  always_ff @(posedge clk) begin
    if (en) begin
      k1   <= sq_out;
      m_1  <= root;
      epm1 <= {1'b0, sq_out.e_mag} + {1'b0, root};

      k2   <= k1;
      m_2  <= m_1;
      den2 <= {32'b0, m_1} * {31'b0, epm1};
      dep2 <= $signed({{34{k1.de[31]}}, k1.de}) * $signed({33'b0, epm1});

      k3   <= k2;
      m_3  <= m_2;
      den3 <= den2;
      nc3  <= {k2.s[65], k2.s} + {dep2[65], dep2};

      bad4    <= k3.bad;
      ne_neg4 <= k3.ne[66];
      ne_mag4 <= ne_abs[65:0];
      nc_neg4 <= nc3[66];
      nc_mag4 <= nc_abs[65:0];
      amag4   <= amag3;
      d4      <= k3.d;
      den4    <= den3;
      m_4     <= m_3;
      for (int i = 0; i < 3; i++) begin
        aneg4[i] <= k3.a[i][31];
      end

      bad5    <= bad4;
      ne_neg5 <= ne_neg4;
      enum5   <= ne_mag4 + {35'b0, m_4[31:1]};
      d5      <= d4;
      den5    <= den4;
      m_5     <= m_4;
      for (int i = 0; i < 3; i++) begin
        tneg5[i] <= nc_neg4 ^ aneg4[i];
        ph5[i]   <= nc_mag4[65:33] * {1'b0, amag4[i]};
        pl5[i]   <= nc_mag4[32:0] * {1'b0, amag4[i]};
      end
    end
  end

  // Momentum numerators with the rounding half of the divisor.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      nump[i] = {1'b0, ph5[i], 33'b0} + {34'b0, pl5[i]} + {36'b0, den5[63:1]};
    end
  end

  lbl_div #(.NW(66), .DW(32), .TW(2)) u_div_e (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .vld_in  (v_m5),
    .num     (enum5),
    .den     (m_5),
    .tag     ({bad5, ne_neg5}),
    .vld_out (vd_e),
    .quo     (qe),
    .tag_out (tg_e)
  );

  for (genvar g = 0; g < 3; g++) begin : g_mom
    lbl_div #(.NW(99), .DW(64), .TW(33)) u_div_p (
      .clk     (clk),
      .rst     (rst),
      .en      (en),
      .vld_in  (v_m5),
      .num     (nump[g]),
      .den     (den5),
      .tag     ({tneg5[g], d5[g]}),
      .vld_out (vd_p[g]),
      .quo     (qp[g]),
      .tag_out (tgp[g])
    );
  end

  // Signs, daughter offset and saturation; a bad parent gives zeros.
  always_comb begin
    out_next.bad_parent = tg_e[1];
    out_next.lab_energy = sat32(sgn_quo(qe, tg_e[0]));
    out_next.lab_px = sat32(sgn_quo(qp[0], tgp[0][32])
                            + {{4{tgp[0][31]}}, tgp[0][31:0]});
    out_next.lab_py = sat32(sgn_quo(qp[1], tgp[1][32])
                            + {{4{tgp[1][31]}}, tgp[1][31:0]});
    out_next.lab_pz = sat32(sgn_quo(qp[2], tgp[2][32])
                            + {{4{tgp[2][31]}}, tgp[2][31:0]});
    if (tg_e[1]) begin
      out_next.lab_px     = '0;
      out_next.lab_py     = '0;
      out_next.lab_pz     = '0;
      out_next.lab_energy = '0;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= vd_e & (&vd_p);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data <= out_next;
    end
  end

  // A flagged parent never shows a non-zero result.
  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.bad_parent |->
      out_data.lab_px == '0 && out_data.lab_py == '0 &&
      out_data.lab_pz == '0 && out_data.lab_energy == '0)
    else $error("bad parent beat carries a non-zero result");

  // The four dividers stay in lock step.
  a_lanes: assert property (@(posedge clk) disable iff (rst)
    vd_p == {3{vd_e}})
    else $error("divider lanes out of step");

  // A good parent has a mass of at least one unit, so the root is non-zero.
  a_root: assert property (@(posedge clk) disable iff (rst)
    v_sq && !sq_out.bad |-> root != '0)
    else $error("zero mass for a good parent");

  // Reset leaves no result on the output.
  a_rst: assert property (@(posedge clk) !rst && $past(rst) |-> !out_valid)
    else $error("output valid straight after reset");

endmodule
